// ===== hw/rtl/sliding_window_median_unit_macros.svh =====
// ----------------------------------------------------------------------------
// sliding window median unit assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_UNIT_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_UNIT_MACROS_SVH

// same-cycle implication
`define SWMU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sliding window median unit check failed");

// next-cycle implication
`define SWMU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sliding window median unit check failed");

`endif

// ===== hw/rtl/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg
// shared types and constants of the sliding window median unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swm_pkg;

  localparam int unsigned SampleW   = 32;
  localparam int unsigned MedianW   = 33;
  localparam int unsigned CfgW      = 6;
  localparam logic [CfgW-1:0] CfgReset = 6'd3;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ADJUST = 4'b0010,
    ST_RD_LO  = 4'b0100,
    ST_RD_HI  = 4'b1000
  } state_e;

  typedef struct packed {
    logic load;
    logic evict;
    logic insert;
    logic rd_lo;
    logic rd_hi;
  } cmd_t;

  typedef struct packed {
    logic fill_ge_win;
    logic fill_hits_win;
    logic out_free;
  } status_t;

endpackage

// ===== hw/rtl/swm_dp.sv =====
// ----------------------------------------------------------------------------
// swm_dp
// sorted cell row with age tags, window register, median read and output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swm_dp #(
  parameter int unsigned WINDOW_MAX = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  swm_pkg::cmd_t                          cmd_i,
  output swm_pkg::status_t                       status_o,
  input  logic                                   cfg_we_i,
  input  logic [swm_pkg::CfgW-1:0]               cfg_wdata_i,
  input  logic                                   start_series_i,
  input  logic signed [swm_pkg::SampleW-1:0]     sample_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [swm_pkg::MedianW-1:0]     median_doubled_o
);

  localparam int unsigned CntW = $clog2(WINDOW_MAX + 1);
  localparam int unsigned IdxW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned SW   = swm_pkg::SampleW;
  localparam int unsigned MW   = swm_pkg::MedianW;

  logic [swm_pkg::CfgW-1:0] window_size_q;
  logic [CntW-1:0]          win_eff;
  logic [CntW-1:0]          fill_q, fill_d;
  logic [IdxW-1:0]          oldest_age;
  logic [IdxW-1:0]          lo_idx, hi_idx;
  logic signed [SW-1:0]     sample_q;
  logic signed [SW-1:0]     lo_q;
  logic signed [MW-1:0]     out_q;
  logic                     out_valid_q, out_valid_d;

  logic signed [SW-1:0] val_q [WINDOW_MAX];
  logic signed [SW-1:0] val_d [WINDOW_MAX];
  logic [IdxW-1:0]      age_q [WINDOW_MAX];
  logic [IdxW-1:0]      age_d [WINDOW_MAX];
  logic [WINDOW_MAX-1:0] evict_hit, evict_pre, gt;

  always_comb begin
    if (window_size_q == '0) begin
      win_eff = CntW'(1);
    end else if (32'(window_size_q) > 32'(WINDOW_MAX)) begin
      win_eff = CntW'(WINDOW_MAX);
    end else begin
      win_eff = CntW'(window_size_q);
    end
  end

  assign oldest_age = IdxW'(fill_q - CntW'(1));
  assign lo_idx     = IdxW'((win_eff - CntW'(1)) >> 1);
  assign hi_idx     = IdxW'(win_eff >> 1);

  for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
    logic                 lt_fill, at_fill, dn_gt;
    logic signed [SW-1:0] up_val, dn_val;
    logic [IdxW-1:0]      up_age, dn_age;

    assign lt_fill      = CntW'(g) < fill_q;
    assign at_fill      = CntW'(g) == fill_q;
    assign evict_hit[g] = lt_fill && (age_q[g] == oldest_age);
    assign gt[g]        = lt_fill && (val_q[g] > sample_q);

    if (g == 0) begin : g_first
      assign evict_pre[g] = evict_hit[g];
      assign dn_gt        = 1'b0;
      assign dn_val       = val_q[g];
      assign dn_age       = age_q[g];
    end else begin : g_rest
      assign evict_pre[g] = evict_pre[g-1] | evict_hit[g];
      assign dn_gt        = gt[g-1];
      assign dn_val       = val_q[g-1];
      assign dn_age       = age_q[g-1];
    end

    if (g < WINDOW_MAX - 1) begin : g_up
      assign up_val = val_q[g+1];
      assign up_age = age_q[g+1];
    end else begin : g_top
      assign up_val = val_q[g];
      assign up_age = age_q[g];
    end

    always_comb begin
      val_d[g] = val_q[g];
      age_d[g] = age_q[g];
      if (cmd_i.evict && evict_pre[g]) begin
        val_d[g] = up_val;
        age_d[g] = up_age;
      end else if (cmd_i.insert) begin
        if (dn_gt) begin
          val_d[g] = dn_val;
          age_d[g] = dn_age + IdxW'(1);
        end else if (gt[g] || at_fill) begin
          val_d[g] = sample_q;
          age_d[g] = '0;
        end else if (lt_fill) begin
          age_d[g] = age_q[g] + IdxW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    age_q <= age_d;
  end

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.load && start_series_i) begin
      fill_d = '0;
    end else if (cmd_i.evict) begin
      fill_d = fill_q - CntW'(1);
    end else if (cmd_i.insert) begin
      fill_d = fill_q + CntW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.rd_hi) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= swm_pkg::CfgReset;
      fill_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        window_size_q <= cfg_wdata_i;
      end
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= sample_i;
    end
    if (cmd_i.rd_lo) begin
      lo_q <= val_q[lo_idx];
    end
    if (cmd_i.rd_hi) begin
      out_q <= {lo_q[SW-1], lo_q} + {val_q[hi_idx][SW-1], val_q[hi_idx]};
    end
  end

  assign status_o.fill_ge_win   = fill_q >= win_eff;
  assign status_o.fill_hits_win = (fill_q + CntW'(1)) == win_eff;
  assign status_o.out_free      = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign median_doubled_o = out_q;

endmodule

// ===== hw/rtl/swm_ctrl.sv =====
// ----------------------------------------------------------------------------
// swm_ctrl
// sequencer for accept, eviction, insertion and median read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  swm_pkg::status_t status_i,
  output swm_pkg::cmd_t    cmd_o
);

  swm_pkg::state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      swm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = swm_pkg::ST_ADJUST;
        end
      end
      swm_pkg::ST_ADJUST: begin
        if (status_i.fill_ge_win) begin
          cmd_o.evict = 1'b1;
        end else begin
          cmd_o.insert = 1'b1;
          state_d = status_i.fill_hits_win ? swm_pkg::ST_RD_LO : swm_pkg::ST_IDLE;
        end
      end
      swm_pkg::ST_RD_LO: begin
        cmd_o.rd_lo = 1'b1;
        state_d     = swm_pkg::ST_RD_HI;
      end
      swm_pkg::ST_RD_HI: begin
        if (status_i.out_free) begin
          cmd_o.rd_hi = 1'b1;
          state_d     = swm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = swm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/sliding_window_median_unit.sv =====
// Sliding window median unit: keeps the last window_size signed samples in a
// row of sorted cells, each tagged with its age, and once the window is full
// returns twice the median (sum of the two middle entries for an even window)
// for every sample. A sample with start_series set empties the window first.
// An item that gives no result is transferred and then inserted into the
// cell row. One that gives a result is transferred, has the oldest sample
// evicted first once the window is full, is inserted, and then has the
// median read out of the cell row one entry at a time, the lower middle
// entry first. Samples beyond the window after window_size is lowered
// mid-series are all evicted the same way before the insertion. A finished
// result waits in the output register while the next sample is taken; the
// unit only stalls when a second result is ready before the first has been transferred.
// ----------------------------------------------------------------------------
// sliding_window_median_unit
// top level: controller and sorted cell datapath
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_window_median_unit #(
  parameter int unsigned WINDOW_MAX = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [swm_pkg::CfgW-1:0]           cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               start_series_i,
  input  logic signed [swm_pkg::SampleW-1:0] sample_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [swm_pkg::MedianW-1:0] median_doubled_o
);

  swm_pkg::cmd_t    cmd;
  swm_pkg::status_t status;

  swm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  swm_dp #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start_series_i   (start_series_i),
    .sample_i         (sample_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .median_doubled_o (median_doubled_o)
  );

endmodule

// ===== hw/rtl/swm_checker.sv =====
// ----------------------------------------------------------------------------
// swm_checker
// port-level assertions for the sliding window median unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sliding_window_median_unit_macros.svh"

module swm_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [swm_pkg::MedianW-1:0] median_doubled_o
);

  `SWMU_ASSERT_NEXT(a_out_valid_holds, out_valid_o && !out_ready_i, out_valid_o)
  `SWMU_ASSERT_NEXT(a_out_data_holds, out_valid_o && !out_ready_i, $stable(median_doubled_o))
  `SWMU_ASSERT_NEXT(a_busy_after_transfer, in_valid_i && in_ready_o, !in_ready_o)
  `SWMU_ASSERT_IMPL(a_result_after_work, $rose(out_valid_o), !$past(in_ready_o))

endmodule

bind sliding_window_median_unit swm_checker u_swm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .median_doubled_o (median_doubled_o)
);
